### rtl/mdf_pkg.sv
// Shared types and constants for the MAC destination filter.
// Used by mdf_ram and mac_destination_filter_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int ADDR_W          = 48;

    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 48'hFFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] STATION_RESET  = 48'h536B_7945_7965;

    // configuration register indexes
    localparam int              CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMISC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION = 1'b1;

    typedef enum logic [1:0] {
        OP_CHECK  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

`default_nettype wire

### rtl/mdf_ram.sv
// Multicast list storage: one write port, one registered read port.
// Depends on mdf_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module mdf_ram
    import mdf_pkg::*;
#(
    parameter int DEPTH = MAX_ENTRIES_DEF,
    parameter int AW    = 5,
    parameter int DW    = ADDR_W
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/mac_destination_filter_core.sv
// A check settled by promiscuous mode, station or broadcast, a no-op and an add to a
// full list go from S_IDLE straight to S_DONE; other items scan the list in S_SCAN (a
// listed check stops at the hit), and a remove that hits then shifts the later entries
// down in S_SHIFT. From S_DONE the result is loaded into the output register that drives
// result_valid. One item at a time: a new item is taken only in S_IDLE, after the result
// is loaded; a held result stalls the input. Reset: rst_n async low; list empty,
// promiscuous on, station at its default. Depends on mdf_pkg and mdf_ram.
`timescale 1ns / 1ps
`default_nettype none

module mac_destination_filter_core
    import mdf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] reg_index,
    input  wire logic [ADDR_W-1:0]    wr_data,
    // item channel
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [1:0]           op,
    input  wire logic [ADDR_W-1:0]    mac_addr,
    // result channel
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic                      accept,
    output logic                      status
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // configuration
    logic              promisc_reg;
    logic [ADDR_W-1:0] station_reg;

    // sequencer
    state_t            state_reg,    state_next;
    op_t               op_reg,       op_next;
    logic [ADDR_W-1:0] addr_reg,     addr_next;
    logic [CW-1:0]     count_reg,    count_next;
    logic [CW-1:0]     idx_reg,      idx_next;
    logic              pend_reg,     pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic              res_acc_reg,  res_acc_next;
    logic              res_sts_reg,  res_sts_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg,   out_acc_next;
    logic              out_sts_reg,   out_sts_next;

    // memory port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ADDR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_rdata;

    logic              take_item;
    logic              hit;
    logic              more;
    logic [CW-1:0]     idx_m1;
    logic [CW-1:0]     after_hit;

    assign item_ready = (state_reg == S_IDLE);
    assign take_item  = item_valid && item_ready;

    // the entry read last cycle matches the item address
    assign hit       = pend_reg && (ram_rdata == addr_reg);
    assign more      = (idx_reg < count_reg);
    assign idx_m1    = idx_reg - CW'(1);
    assign after_hit = CW'(pend_idx_reg) + CW'(1);

    // Configuration registers: the user must write them only while idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promisc_reg <= 1'b1;
            station_reg <= STATION_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                CFG_PROMISC: promisc_reg <= wr_data[0];
                CFG_STATION: station_reg <= wr_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        res_acc_next   = res_acc_reg;
        res_sts_next   = res_sts_reg;
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_sts_next   = out_sts_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_idx_reg;
        ram_wdata      = ram_rdata;

        // drop the result once the consumer takes it
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take_item)
                begin
                    op_next      = op_t'(op);
                    addr_next    = mac_addr;
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    res_acc_next = 1'b0;
                    res_sts_next = 1'b0;
                    unique case (op_t'(op))
                        OP_CHECK:
                        begin
                            // fixed addresses need no scan
                            if (promisc_reg || mac_addr == station_reg
                                || mac_addr == BROADCAST_ADDR)
                            begin
                                res_acc_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_ADD:
                        begin
                            // a full list refuses even a duplicate
                            if (count_reg == MAX_COUNT)
                            begin
                                res_sts_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_REMOVE: state_next = S_SCAN;
                        OP_NONE:   state_next = S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    unique case (op_reg)
                        OP_CHECK:
                        begin
                            res_acc_next = 1'b1;
                            state_next   = S_DONE;
                        end
                        OP_REMOVE:
                        begin
                            // close the gap starting with the entry after the hit
                            idx_next   = after_hit;
                            pend_next  = 1'b0;
                            state_next = S_SHIFT;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
                else if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    // not listed: an add appends at the end
                    if (op_reg == OP_ADD)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        ram_wdata  = addr_reg;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // write back the entry read last cycle one place lower
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_m1[AW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_sts_next   = res_sts_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        pend_idx_reg <= pend_idx_next;
        res_acc_reg  <= res_acc_next;
        res_sts_reg  <= res_sts_next;
        out_acc_reg  <= out_acc_next;
        out_sts_reg  <= out_sts_next;
    end

    mdf_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .DW    (ADDR_W)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign result_valid = out_valid_reg;
    assign accept       = out_acc_reg;
    assign status       = out_sts_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("entry count above list size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_SCAN) |-> (count_reg < MAX_COUNT))
        else $error("append into a full list");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pend_reg) |-> (after_hit < count_reg))
        else $error("shift writes outside the live entries");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("entry count moved while idle");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_acc_reg && out_sts_reg))
        else $error("accept and refusal flagged together");
`endif

endmodule

`default_nettype wire
